>>> rtl/symmetric_pair_gradient_climb_top_defines.svh
// assertion macros shared by the climb block
`ifndef SYMMETRIC_PAIR_GRADIENT_CLIMB_TOP_DEFINES_SVH
`define SYMMETRIC_PAIR_GRADIENT_CLIMB_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SPGC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SPGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spgc_pkg.sv
package spgc_pkg;

  localparam int ImageWidth  = 256;
  localparam int ImageHeight = 256;
  localparam int GradBits    = 16;
  localparam int MaxStride   = 4;
  localparam int MaxMoves    = 1024;
  localparam int LoadSide    = 256;

  // working coordinates: 16 bit inputs plus two 16 bit shifts plus climb drift
  localparam int CoordW  = 24;
  localparam int StrideW = 3;
  localparam int CountW  = $clog2(MaxMoves + 1);
  localparam int SumW    = GradBits + 1;
  localparam int AddrW   = 16;

  // register indexes
  localparam logic [2:0] RegOffsetX  = 3'd0;
  localparam logic [2:0] RegOffsetY  = 3'd1;
  localparam logic [2:0] RegGrowthX  = 3'd2;
  localparam logic [2:0] RegGrowthY  = 3'd3;
  localparam logic [2:0] RegStepDirX = 3'd4;
  localparam logic [2:0] RegStepDirY = 3'd5;
  localparam logic [2:0] RegLookAhd  = 3'd6;

  // request codes
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqMove = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  // map read request from the sequencer
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
  } rd_req_t;

  // map read answer, registered and given in the cycle after the request
  typedef struct packed {
    logic                valid;
    logic [GradBits-1:0] value;
  } rd_rsp_t;

  // point inside the map
  function automatic logic in_map(input coord_t x, input coord_t y);
    in_map = (x >= 0) && (x < coord_t'(ImageWidth)) &&
             (y >= 0) && (y < coord_t'(ImageHeight));
  endfunction

  // q2.14 times a small stride, rounded half away from zero
  function automatic coord_t scale_round(input logic signed [15:0] q,
                                         input logic [StrideW-1:0] s);
    logic signed [19:0] p;
    logic        [19:0] mag;
    logic        [19:0] r;
    p   = q * $signed({1'b0, s});
    mag = p[19] ? 20'(-p) : 20'(p);
    r   = (mag + 20'd8192) >> 14;
    scale_round = p[19] ? -coord_t'(r) : coord_t'(r);
  endfunction

endpackage

>>> rtl/symmetric_pair_gradient_climb_top.sv
// channel | direction | handshake      | payload
// in      | input     | in_valid/stall | req_type, pixel_*, grad_value, first_*, second_*
// out     | output    | out_valid/stall| moved_first_*, moved_second_*
// cfg     | input     | apb            | 7 registers at 4*i
// a load item is written straight into the map; a move item climbs in trials, each one
// a set-up state, six map reads through the single read port, then a decision
// reset is synchronous and active high; the map is not cleared
// in_stall is high while a move climbs or its result waits in the output register
module symmetric_pair_gradient_climb_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  input  logic [15:0]        grad_value,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] moved_first_x,
  output logic signed [15:0] moved_first_y,
  output logic signed [15:0] moved_second_x,
  output logic signed [15:0] moved_second_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import spgc_pkg::*;
  `include "symmetric_pair_gradient_climb_top_defines.svh"

  logic signed [15:0] offset_x, offset_y, growth_x, growth_y, step_dir_x, step_dir_y;
  logic               look_ahead;
  logic               busy;
  logic               in_acc;
  logic               start;
  logic               done;
  rd_req_t            rd_req;
  rd_rsp_t            rd_rsp;
  coord_t             fin_ax, fin_ay, fin_bx, fin_by;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0; offset_y <= '0; growth_x <= '0; growth_y <= '0;
      step_dir_x <= 16'sd16384; step_dir_y <= '0; look_ahead <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegOffsetX:  offset_x   <= pwdata[15:0];
        RegOffsetY:  offset_y   <= pwdata[15:0];
        RegGrowthX:  growth_x   <= pwdata[15:0];
        RegGrowthY:  growth_y   <= pwdata[15:0];
        RegStepDirX: step_dir_x <= pwdata[15:0];
        RegStepDirY: step_dir_y <= pwdata[15:0];
        RegLookAhd:  look_ahead <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      RegOffsetX:  prdata = 32'(offset_x);
      RegOffsetY:  prdata = 32'(offset_y);
      RegGrowthX:  prdata = 32'(growth_x);
      RegGrowthY:  prdata = 32'(growth_y);
      RegStepDirX: prdata = 32'(step_dir_x);
      RegStepDirY: prdata = 32'(step_dir_y);
      RegLookAhd:  prdata = {31'd0, look_ahead};
      default:     prdata = '0;
    endcase
  end

  // input handshake
  assign in_stall = busy || out_valid;
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (req_type == ReqMove);

  always_ff @(posedge clk) begin
    if (rst)       busy <= 1'b0;
    else if (start) busy <= 1'b1;
    else if (done)  busy <= 1'b0;
  end

  spgc_map u_map (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_acc && (req_type == ReqLoad)),
    .wr_x    (pixel_x),
    .wr_y    (pixel_y),
    .wr_data (grad_value),
    .rd_req  (rd_req),
    .rd_rsp  (rd_rsp)
  );

  spgc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .init_ax    (coord_t'(first_x) + coord_t'(offset_x) + coord_t'(growth_x)),
    .init_ay    (coord_t'(first_y) + coord_t'(offset_y) + coord_t'(growth_y)),
    .init_bx    (coord_t'(second_x) + coord_t'(offset_x) + coord_t'(growth_x)),
    .init_by    (coord_t'(second_y) + coord_t'(offset_y) + coord_t'(growth_y)),
    .dir_x      (step_dir_x),
    .dir_y      (step_dir_y),
    .look_ahead (look_ahead),
    .rd_req     (rd_req),
    .rd_rsp     (rd_rsp),
    .done       (done),
    .fin_ax     (fin_ax),
    .fin_ay     (fin_ay),
    .fin_bx     (fin_bx),
    .fin_by     (fin_by)
  );

  // output register, offset removed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      moved_first_x  <= 16'(fin_ax - coord_t'(offset_x));
      moved_first_y  <= 16'(fin_ay - coord_t'(offset_y));
      moved_second_x <= 16'(fin_bx - coord_t'(offset_x));
      moved_second_y <= 16'(fin_by - coord_t'(offset_y));
    end
  end

  `SPGC_ASSERT_IMP(a_no_start_busy, busy, !start, "move started while busy")
  `SPGC_ASSERT_IMP(a_done_busy, done, busy, "climb finished while idle")
  `SPGC_ASSERT_NEXT(a_out_after_done, done, out_valid, "result lost after climb")

endmodule

>>> rtl/spgc_map.sv
module spgc_map (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [7:0]                wr_x,
  input  logic [7:0]                wr_y,
  input  logic [15:0]               wr_data,
  input  spgc_pkg::rd_req_t         rd_req,
  output spgc_pkg::rd_rsp_t         rd_rsp
);
  import spgc_pkg::*;

  logic [GradBits-1:0] mem [LoadSide*LoadSide];
  logic [GradBits-1:0] rd_data;
  logic                rd_hit;
  logic                rd_valid;
  logic                hit;

  // loadable area and map bounds
  assign hit = in_map(rd_req.x, rd_req.y) &&
               (rd_req.x < coord_t'(LoadSide)) && (rd_req.y < coord_t'(LoadSide));

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_y, wr_x}] <= wr_data[GradBits-1:0];
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[{rd_req.y[7:0], rd_req.x[7:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_hit   <= 1'b0;
    end else begin
      rd_valid <= rd_req.valid;
      rd_hit   <= hit;
    end
  end

  assign rd_rsp.valid = rd_valid;
  assign rd_rsp.value = rd_hit ? rd_data : '0;

endmodule

>>> rtl/spgc_seq.sv
module spgc_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  spgc_pkg::coord_t      init_ax,
  input  spgc_pkg::coord_t      init_ay,
  input  spgc_pkg::coord_t      init_bx,
  input  spgc_pkg::coord_t      init_by,
  input  logic signed [15:0]    dir_x,
  input  logic signed [15:0]    dir_y,
  input  logic                  look_ahead,
  output spgc_pkg::rd_req_t     rd_req,
  input  spgc_pkg::rd_rsp_t     rd_rsp,
  output logic                  done,
  output spgc_pkg::coord_t      fin_ax,
  output spgc_pkg::coord_t      fin_ay,
  output spgc_pkg::coord_t      fin_bx,
  output spgc_pkg::coord_t      fin_by
);
  import spgc_pkg::*;
  `include "symmetric_pair_gradient_climb_top_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_READ  = 5'b00100,
    S_DEC   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  coord_t ax, ay, bx, by;
  coord_t dx, dy;
  logic [StrideW-1:0] stride;
  logic [CountW-1:0]  move_count;
  // read slot 0..5: here a, here b, in a, in b, out a, out b
  logic [2:0]         slot;
  logic [2:0]         rsp_slot;
  logic [SumW-1:0]    p_here, p_in, p_out;
  logic               cand_ok;
  logic [SumW-1:0]    p_out_fin;
  logic [SumW-1:0]    best;
  logic               go_in;
  logic               moved;

  coord_t rx, ry;

  // candidate points for the current slot
  always_comb begin
    rx = ax;
    ry = ay;
    case (slot)
      3'd0: begin rx = ax; ry = ay; end
      3'd1: begin rx = bx; ry = by; end
      3'd2: begin rx = ax + dx; ry = ay + dy; end
      3'd3: begin rx = bx - dx; ry = by - dy; end
      3'd4: begin rx = ax - dx; ry = ay - dy; end
      3'd5: begin rx = bx + dx; ry = by + dy; end
      default: begin rx = ax; ry = ay; end
    endcase
  end

  assign rd_req.valid = (state == S_READ);
  assign rd_req.x     = rx;
  assign rd_req.y     = ry;

  // last response lands while in the decide state
  assign p_out_fin = p_out + SumW'(rd_rsp.value);
  assign go_in     = p_in > p_out_fin;
  assign best      = go_in ? p_in : p_out_fin;
  assign moved     = cand_ok && (best > p_here);

  // state transitions
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_STEP;
      S_STEP: begin
        if (move_count >= CountW'(MaxMoves)) state_next = S_DONE;
        else                                  state_next = S_READ;
      end
      S_READ: if (slot == 3'd5) state_next = S_DEC;
      S_DEC: begin
        if (rd_rsp.valid) begin
          if (moved || (look_ahead && stride < StrideW'(MaxStride))) state_next = S_STEP;
          else                                                      state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stride     <= StrideW'(1);
      move_count <= '0;
      slot       <= '0;
      rsp_slot   <= '0;
      ax <= '0; ay <= '0; bx <= '0; by <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            ax <= init_ax; ay <= init_ay; bx <= init_bx; by <= init_by;
            stride     <= StrideW'(1);
            move_count <= '0;
          end
        end
        S_STEP: begin
          dx       <= scale_round(dir_x, stride);
          dy       <= scale_round(dir_y, stride);
          slot     <= '0;
          rsp_slot <= '0;
          p_here   <= '0;
          p_in     <= '0;
          p_out    <= '0;
          cand_ok  <= 1'b1;
        end
        S_READ: begin
          slot <= slot + 3'd1;
          if (slot >= 3'd2 && !in_map(rx, ry)) cand_ok <= 1'b0;
        end
        default: ;
      endcase

      // accumulate map answers
      if (rd_rsp.valid) begin
        rsp_slot <= rsp_slot + 3'd1;
        if (rsp_slot <= 3'd1)      p_here <= p_here + SumW'(rd_rsp.value);
        else if (rsp_slot <= 3'd3) p_in   <= p_in + SumW'(rd_rsp.value);
        else                       p_out  <= p_out + SumW'(rd_rsp.value);
      end

      // decide on the move
      if (state == S_DEC && rd_rsp.valid) begin
        if (moved) begin
          move_count <= move_count + CountW'(1);
          if (go_in) begin
            ax <= ax + dx; ay <= ay + dy; bx <= bx - dx; by <= by - dy;
          end else begin
            ax <= ax - dx; ay <= ay - dy; bx <= bx + dx; by <= by + dy;
          end
        end else if (look_ahead && stride < StrideW'(MaxStride)) begin
          stride <= stride + StrideW'(1);
        end
      end
    end
  end

  assign done   = (state == S_DONE);
  assign fin_ax = ax;
  assign fin_ay = ay;
  assign fin_bx = bx;
  assign fin_by = by;

  `SPGC_ASSERT_IMP(a_cap, state != S_IDLE, move_count <= CountW'(MaxMoves),
    "move count beyond cap")
  `SPGC_ASSERT_IMP(a_stride, state != S_IDLE,
    stride >= StrideW'(1) && stride <= StrideW'(MaxStride), "stride out of range")
  `SPGC_ASSERT_NEXT(a_done, state == S_DONE, state == S_IDLE, "done not followed by idle")

endmodule

>>> tb/spgc_climb_checker.sv
// watches the item channels and the register port, predicts every moved pair
// and compares it with what the block emits
module spgc_climb_checker
  import spgc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         pixel_x,
  input  logic [7:0]         pixel_y,
  input  logic [15:0]        grad_value,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] moved_first_x,
  input  logic signed [15:0] moved_first_y,
  input  logic signed [15:0] moved_second_x,
  input  logic signed [15:0] moved_second_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_pairs,
  output int                 pairs_checked
);

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
  } pair_t;

  // shadow of the block's registers and gradient map
  logic signed [15:0] sh_off_x, sh_off_y, sh_grow_x, sh_grow_y;
  logic signed [15:0] sh_dir_x, sh_dir_y;
  logic               sh_look;
  logic [15:0]        grad_map [0:65535];
  pair_t              moved_pairs [$];

  function automatic int unsigned grad_at(input int x, input int y);
    if (x < 0 || x >= ImageWidth || y < 0 || y >= ImageHeight) return 0;
    return grad_map[{y[7:0], x[7:0]}];
  endfunction

  function automatic int in_frame(input int x, input int y);
    return (x >= 0 && x < ImageWidth && y >= 0 && y < ImageHeight);
  endfunction

  // direction times stride, rounded half away from zero
  function automatic int step_len(input int q, input int s);
    int p;
    p = q * s;
    if (p >= 0) return (p + 8192) / 16384;
    return -((-p + 8192) / 16384);
  endfunction

  // climb the pair over the map and give it back in the caller's frame
  function automatic pair_t climb_pair(input int fx, input int fy, input int sx,
                                       input int sy);
    int ax, ay, bx, by, dx, dy, strd, moves;
    int unsigned here, pin, pout, best;
    logic moved;
    pair_t r;
    ax = fx + sh_off_x + sh_grow_x;
    ay = fy + sh_off_y + sh_grow_y;
    bx = sx + sh_off_x + sh_grow_x;
    by = sy + sh_off_y + sh_grow_y;
    strd = 1;
    moves = 0;
    while (moves < MaxMoves) begin
      moved = 1'b0;
      here = grad_at(ax, ay) + grad_at(bx, by);
      dx = step_len(sh_dir_x, strd);
      dy = step_len(sh_dir_y, strd);
      if (in_frame(ax + dx, ay + dy) && in_frame(bx - dx, by - dy) &&
          in_frame(ax - dx, ay - dy) && in_frame(bx + dx, by + dy)) begin
        pin  = grad_at(ax + dx, ay + dy) + grad_at(bx - dx, by - dy);
        pout = grad_at(ax - dx, ay - dy) + grad_at(bx + dx, by + dy);
        best = (pin > pout) ? pin : pout;
        if (best > here) begin
          moved = 1'b1;
          moves++;
          // ties between the two candidates go outward
          if (pin > pout) begin
            ax = ax + dx; ay = ay + dy; bx = bx - dx; by = by - dy;
          end else begin
            ax = ax - dx; ay = ay - dy; bx = bx + dx; by = by + dy;
          end
        end
      end
      if (!moved) begin
        if (sh_look && strd < MaxStride) strd++;
        else break;
      end
    end
    r.ax = 16'(ax - sh_off_x);
    r.ay = 16'(ay - sh_off_y);
    r.bx = 16'(bx - sh_off_x);
    r.by = 16'(by - sh_off_y);
    return r;
  endfunction

  // register writes, accepted items and emitted pairs
  always @(posedge clk) begin
    pair_t want, got;
    if (rst) begin
      sh_off_x  <= '0;
      sh_off_y  <= '0;
      sh_grow_x <= '0;
      sh_grow_y <= '0;
      sh_dir_x  <= 16'sd16384;
      sh_dir_y  <= '0;
      sh_look   <= 1'b0;
      moved_pairs.delete();
      fail_count    = 0;
      pairs_checked = 0;
      pending_pairs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegOffsetX:  sh_off_x  <= pwdata[15:0];
          RegOffsetY:  sh_off_y  <= pwdata[15:0];
          RegGrowthX:  sh_grow_x <= pwdata[15:0];
          RegGrowthY:  sh_grow_y <= pwdata[15:0];
          RegStepDirX: sh_dir_x  <= pwdata[15:0];
          RegStepDirY: sh_dir_y  <= pwdata[15:0];
          RegLookAhd:  sh_look   <= pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (req_type == ReqLoad)
          grad_map[{pixel_y, pixel_x}] = grad_value;
        else
          moved_pairs.push_back(climb_pair(first_x, first_y, second_x, second_y));
      end
      if (out_valid && !out_stall) begin
        got = '{moved_first_x, moved_first_y, moved_second_x, moved_second_y};
        if (moved_pairs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pair %0d,%0d %0d,%0d", got.ax, got.ay, got.bx, got.by);
        end else begin
          want = moved_pairs.pop_front();
          pairs_checked++;
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pair mismatch: expected %0d,%0d %0d,%0d got %0d,%0d %0d,%0d",
                       want.ax, want.ay, want.bx, want.by,
                       got.ax, got.ay, got.bx, got.by);
          end
        end
      end
      pending_pairs = moved_pairs.size();
    end
  end

endmodule

>>> tb/symmetric_pair_gradient_climb_top_tb.sv
module symmetric_pair_gradient_climb_top_tb;
  import spgc_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;
  // the two map rows that are loaded in full
  localparam logic [7:0] RowLow  = 8'd0;
  localparam logic [7:0] RowHigh = 8'd255;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = ReqLoad;
  logic [7:0]         pixel_x = '0;
  logic [7:0]         pixel_y = '0;
  logic [15:0]        grad_value = '0;
  logic signed [15:0] first_x = '0;
  logic signed [15:0] first_y = '0;
  logic signed [15:0] second_x = '0;
  logic signed [15:0] second_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] moved_first_x, moved_first_y, moved_second_x, moved_second_y;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count, pending_pairs, pairs_checked;

  // current register values, used to aim pairs into the map
  logic signed [15:0] cur_off_x = '0, cur_off_y = '0, cur_grow_x = '0, cur_grow_y = '0;
  int                 burst_left = 0;
  logic               no_gaps = 1'b0;
  int                 stall_mode = 0;
  int                 mode_left = 0;
  int                 loads_sent = 0, moves_sent = 0;

  always #5 clk = ~clk;

  symmetric_pair_gradient_climb_top DUT (.*);

  spgc_climb_checker checker_i (.*);

  // receiver stall pattern: free, light or heavy stretches
  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left  <= $urandom_range(20, 200);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_item(input logic rq, input logic [7:0] px, input logic [7:0] py,
                           input logic [15:0] gv, input logic [15:0] fx,
                           input logic [15:0] fy, input logic [15:0] sx,
                           input logic [15:0] sy);
    int gap;
    @(negedge clk);
    req_type   <= rq;
    pixel_x    <= px;
    pixel_y    <= py;
    grad_value <= gv;
    first_x    <= fx;
    first_y    <= fy;
    second_x   <= sx;
    second_y   <= sy;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (rq == ReqLoad) loads_sent++;
    else moves_sent++;
    // bursts of random length with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_load(input logic [7:0] px, input logic [7:0] py,
                           input logic [15:0] gv);
    send_item(ReqLoad, px, py, gv, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic send_move(input logic [15:0] fx, input logic [15:0] fy,
                           input logic [15:0] sx, input logic [15:0] sy);
    send_item(ReqMove, 8'($urandom), 8'($urandom), 16'($urandom), fx, fy, sx, sy);
  endtask

  // coordinate that lands on map column or row m once shifted
  function automatic logic [15:0] aim(input int m, input logic signed [15:0] off,
                                      input logic signed [15:0] grow);
    return 16'(m - off - grow);
  endfunction

  // row for a point: one of the loaded rows, now and then below the map
  function automatic int row_pick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return int'(RowLow);
    if (r < 8) return int'(RowHigh);
    return 256 + int'($urandom_range(0, 1000));
  endfunction

  function automatic logic [7:0] load_row();
    return ($urandom_range(0, 1) == 0) ? RowLow : RowHigh;
  endfunction

  task automatic send_random_move();
    if ($urandom_range(0, 9) < 8)
      send_move(aim($urandom_range(0, 255), cur_off_x, cur_grow_x),
                aim(row_pick(), cur_off_y, cur_grow_y),
                aim($urandom_range(0, 255), cur_off_x, cur_grow_x),
                aim(row_pick(), cur_off_y, cur_grow_y));
    else
      send_move(16'($urandom), aim(row_pick(), cur_off_y, cur_grow_y),
                16'($urandom), aim(row_pick(), cur_off_y, cur_grow_y));
  endtask

  // wait for every pair, then let the block settle before a register write
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pairs != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic signed [15:0] ox, input logic signed [15:0] oy,
                            input logic signed [15:0] gx, input logic signed [15:0] gy,
                            input logic signed [15:0] dx, input logic signed [15:0] dy,
                            input logic la);
    reg_write(RegOffsetX, {16'hffff, ox});
    reg_write(RegOffsetY, {16'h0000, oy});
    reg_write(RegGrowthX, {$urandom} & 32'hffff0000 | 32'(gx) & 32'hffff);
    reg_write(RegGrowthY, 32'(gy) & 32'hffff);
    reg_write(RegStepDirX, 32'(dx) & 32'hffff);
    reg_write(RegStepDirY, 32'(dy) & 32'hffff);
    reg_write(RegLookAhd, {31'(0), la});
    cur_off_x  = ox;
    cur_off_y  = oy;
    cur_grow_x = gx;
    cur_grow_y = gy;
  endtask

  initial begin
    logic signed [15:0] dxr, dyr;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // two whole rows are written; every point sits on one of them or off the map
    // and the y step rounds to zero, so no climb reads an unwritten entry
    no_gaps = 1'b1;
    for (int x = 0; x < 256; x++) begin
      send_load(8'(x), RowLow, $urandom_range(0, 7) == 0 ? 16'hffff : 16'($urandom));
      send_load(8'(x), RowHigh, $urandom_range(0, 7) == 0 ? 16'hffff : 16'($urandom));
    end
    no_gaps = 1'b0;

    // directed: field extremes, corners, points off the map, wrapping
    send_load(8'd0, RowLow, 16'h0000);
    send_load(8'd255, RowHigh, 16'hffff);
    send_load(8'd255, RowLow, 16'h8000);
    send_load(8'd0, RowHigh, 16'h7fff);
    send_move(16'd0, 16'd0, 16'd255, 16'd255);
    send_move(16'd10, 16'd0, 16'd20, 16'd0);
    send_move(16'd128, 16'd255, 16'd128, 16'd255);
    send_move(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_move(-16'sd1, 16'd0, 16'd256, 16'd255);
    send_move(16'd1, 16'd0, 16'd254, 16'd255);
    send_move(16'd0, 16'd255, 16'd255, 16'd0);
    drain();

    // extreme offsets push the pair off the map and wrap on the way back
    set_config(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    reg_write(RegNone, 32'hdeadbeef);
    send_move(16'd0, 16'd0, 16'd5, 16'd5);
    send_move(16'sh8002, 16'sh0000, 16'sh8010, 16'sh0000);
    send_move(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_move(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    // ties and stride growth with a unit step and look-ahead
    set_config(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b1);
    send_move(16'd60, 16'd0, 16'd200, 16'd255);
    send_move(16'd2, 16'd0, 16'd253, 16'd255);
    send_move(16'd100, 16'd255, 16'd100, 16'd255);
    drain();

    // random phases, two steep steps and one wide-open set among them
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin dxr = -16'sd32768; dyr = 16'sd2047; end
        1: begin dxr = 16'sd32767; dyr = -16'sd2047; end
        2: begin dxr = 16'sd0; dyr = 16'sd0; end
        default: begin
          dxr = 16'($signed($urandom_range(0, 65535)) - 32768);
          dyr = 16'($signed($urandom_range(0, 4094)) - 2047);
        end
      endcase
      set_config($urandom_range(0, 3) == 0 ? 16'($urandom)
                                           : 16'(int'($urandom_range(0, 80)) - 40),
                 $urandom_range(0, 3) == 0 ? 16'($urandom)
                                           : 16'(int'($urandom_range(0, 80)) - 40),
                 16'(int'($urandom_range(0, 60)) - 30),
                 16'(int'($urandom_range(0, 60)) - 30),
                 dxr, dyr, ph[0]);
      for (int i = 0; i < 45; i++) begin
        if ($urandom_range(0, 9) < 3)
          send_load(8'($urandom), load_row(), 16'($urandom));
        else
          send_random_move();
      end
      drain();
    end

    $display("covered %0d map loads and %0d pair moves, %0d pairs compared",
             loads_sent, moves_sent, pairs_checked);
    if (fail_count == 0 && pending_pairs == 0)
      $display("symmetric_pair_gradient_climb_top regression: pass");
    else
      $display("symmetric_pair_gradient_climb_top regression: fail");
    $finish;
  end

  // hard limit on run time
  initial begin
    #200000000;
    $display("symmetric_pair_gradient_climb_top regression: fail");
    $finish;
  end

endmodule
